[rtl/ifp_pkg.sv]
// Shared types, codes and sizing for the IMU FIFO frame parser.
// Used by the parser front end, the command queue, the store back end and the top level.
package ifp_pkg;

   // Request operation codes
   localparam logic [1:0] OP_BYTE       = 2'd0;
   localparam logic [1:0] OP_READ_ACCEL = 2'd1;
   localparam logic [1:0] OP_READ_GYRO  = 2'd2;
   localparam logic [1:0] OP_NONE       = 2'd3;

   // Response status codes
   localparam logic [2:0] ST_CONSUMED   = 3'd0;
   localparam logic [2:0] ST_ACCEL      = 3'd1;
   localparam logic [2:0] ST_GYRO       = 3'd2;
   localparam logic [2:0] ST_DROPPED    = 3'd3;
   localparam logic [2:0] ST_READ_OK    = 3'd4;
   localparam logic [2:0] ST_READ_EMPTY = 3'd5;

   // Parser phases
   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SKIP   = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   // Header bits and frame enables
   localparam logic [7:0] HDR_CONTROL = 8'h40;
   localparam logic [7:0] HDR_DATA    = 8'h80;
   localparam logic [1:0] EN_GYRO     = 2'b10;
   localparam logic [1:0] EN_ACCEL    = 2'b01;
   localparam logic [3:0] WORD_BYTES  = 4'd6;

   // Command kinds passed from front end to back end
   localparam logic [1:0] CMD_NOP   = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // Sample store sizing
   localparam int COUNT_W     = 11;
   localparam int COUNT_MAX   = 2047;
   localparam int STORE_DEPTH = 1024;
   localparam int CAPACITY    = (STORE_DEPTH > COUNT_MAX) ? COUNT_MAX : STORE_DEPTH;

   // Command queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]        kind;
      logic              gyro;
      logic [2:0][15:0]  words;   // [0] x, [1] y, [2] z
   } cmd_type;

endpackage

[rtl/ifp_parser.sv]
// Front end of the IMU FIFO frame parser: walks headers and payload bytes.
// Emits one command per accepted request; depends on ifp_pkg.
module ifp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [1:0]       operation,
   input  logic [7:0]       data_byte,
   input  logic             burst_start,
   output ifp_pkg::cmd_type cmd
);
   import ifp_pkg::*;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic [1:0]  en_ff, en_in;
   logic [15:0] word_ff [3];
   logic [15:0] word_in [3];
   logic [7:0]  low_ff, low_in;

   logic [1:0]  phase_c;
   logic [3:0]  left_c;
   logic [1:0]  en_c;
   logic [3:0]  left_dec;
   logic [3:0]  idx_raw;
   logic [2:0]  idx;
   logic [3:0]  kind;
   logic [1:0]  en_next;

   always_comb begin
      // burst start drops any partial frame before the request acts
      phase_c  = burst_start ? PH_HEADER : phase_ff;
      left_c   = burst_start ? 4'd0 : left_ff;
      en_c     = burst_start ? 2'd0 : en_ff;

      phase_in = phase_c;
      left_in  = left_c;
      en_in    = en_c;
      word_in  = word_ff;
      low_in   = low_ff;

      left_dec = 4'd0;
      idx_raw  = 4'd0;
      idx      = 3'd0;
      en_next  = 2'd0;
      kind     = data_byte[5:2];

      cmd.kind  = CMD_NOP;
      cmd.gyro  = 1'b0;
      cmd.words = '0;

      case (operation)
         OP_READ_ACCEL: begin
            cmd.kind = CMD_READ;
            cmd.gyro = 1'b0;
         end
         OP_READ_GYRO: begin
            cmd.kind = CMD_READ;
            cmd.gyro = 1'b1;
         end
         OP_BYTE: begin
            case (phase_c)
               PH_SKIP: begin
                  left_dec = (left_c != 4'd0) ? left_c - 4'd1 : 4'd0;
                  left_in  = left_dec;
                  if (left_dec == 4'd0) begin
                     phase_in = PH_HEADER;
                  end
               end
               PH_DATA: begin
                  idx_raw = (left_c > WORD_BYTES) ? 4'd0 : WORD_BYTES - left_c;
                  idx     = (idx_raw > 4'd5) ? 3'd5 : idx_raw[2:0];
                  if (!idx[0]) begin
                     low_in = data_byte;
                  end else begin
                     word_in[idx[2:1]] = {data_byte, low_ff};
                  end
                  left_in = 4'd5 - {1'b0, idx};
                  if (left_in == 4'd0) begin
                     cmd.kind     = CMD_STORE;
                     cmd.gyro     = (en_c & EN_GYRO) != 2'd0;
                     cmd.words[0] = word_in[0];
                     cmd.words[1] = word_in[1];
                     cmd.words[2] = word_in[2];
                     // gyro triple goes first; accel may follow in the same frame
                     en_next      = en_c & (cmd.gyro ? EN_ACCEL : 2'd0);
                     en_in        = en_next;
                     if (en_next != 2'd0) begin
                        left_in = WORD_BYTES;
                     end else begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
               default: begin
                  phase_in = PH_HEADER;
                  if ((data_byte & HDR_CONTROL) != 8'd0) begin
                     case (kind)
                        4'd0: begin
                           phase_in = PH_SKIP;
                           left_in  = 4'd1;
                        end
                        4'd1: begin
                           phase_in = PH_SKIP;
                           left_in  = 4'd2;
                        end
                        4'd2: begin
                           phase_in = PH_SKIP;
                           left_in  = 4'd4;
                        end
                        default: ;
                     endcase
                  end else if ((data_byte & HDR_DATA) != 8'd0) begin
                     en_in = kind[1:0];
                     if (kind[1:0] != 2'd0) begin
                        phase_in = PH_DATA;
                        left_in  = WORD_BYTES;
                     end
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         left_ff  <= 4'd0;
         en_ff    <= 2'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         en_ff    <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         word_ff <= word_in;
         low_ff  <= low_in;
      end
   end

`ifndef ASSERT_OFF
   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> left_ff != 4'd0)
      else $error("skip phase with no bytes left");
   a_data_state: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (en_ff != 2'd0 && left_ff != 4'd0 && left_ff <= WORD_BYTES))
      else $error("data phase with bad enables or byte count");
`endif

endmodule

[rtl/ifp_cmd_queue.sv]
// Short command queue between the parser front end and the store back end.
// Depends on ifp_pkg for the command type and depth.
module ifp_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ifp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output ifp_pkg::cmd_type pop_cmd
);
   import ifp_pkg::*;

   cmd_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef ASSERT_OFF
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("command queue popped while empty");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("command queue pushed while full");
`endif

endmodule

[rtl/ifp_store.sv]
// Back end of the IMU FIFO frame parser: sample counts, latest triples, response register.
// Depends on ifp_pkg for the command type, status codes and capacity.
module ifp_store (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ifp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [47:0]      rsp_samples
);
   import ifp_pkg::*;

   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

   logic [COUNT_W-1:0] acnt_ff, acnt_in;
   logic [COUNT_W-1:0] gcnt_ff, gcnt_in;
   logic [2:0][15:0]   accel_ff, accel_in;
   logic [2:0][15:0]   gyro_ff, gyro_in;
   logic               valid_ff, valid_in;
   logic [2:0]         status_ff, status_in;
   logic [47:0]        samples_ff, samples_in;
   logic [COUNT_W-1:0] cnt_sel;

   assign cmd_pop     = cmd_valid && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_samples = samples_ff;

   always_comb begin
      acnt_in    = acnt_ff;
      gcnt_in    = gcnt_ff;
      accel_in   = accel_ff;
      gyro_in    = gyro_ff;
      status_in  = ST_CONSUMED;
      samples_in = '0;
      cnt_sel    = cmd.gyro ? gcnt_ff : acnt_ff;

      case (cmd.kind)
         CMD_STORE: begin
            samples_in = cmd.words;
            if (cnt_sel >= CAP) begin
               status_in = ST_DROPPED;
            end else if (cmd.gyro) begin
               status_in = ST_GYRO;
               gyro_in   = cmd.words;
               gcnt_in   = gcnt_ff + 1'b1;
            end else begin
               status_in = ST_ACCEL;
               accel_in  = cmd.words;
               acnt_in   = acnt_ff + 1'b1;
            end
         end
         CMD_READ: begin
            if (cnt_sel != '0) begin
               status_in  = ST_READ_OK;
               samples_in = cmd.gyro ? gyro_ff : accel_ff;
            end else begin
               status_in = ST_READ_EMPTY;
            end
            // a read always clears the count it looked at
            if (cmd.gyro) begin
               gcnt_in = '0;
            end else begin
               acnt_in = '0;
            end
         end
         default: ;
      endcase

      if (cmd_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acnt_ff  <= '0;
         gcnt_ff  <= '0;
         accel_ff <= '0;
         gyro_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd_pop) begin
            acnt_ff  <= acnt_in;
            gcnt_ff  <= gcnt_in;
            accel_ff <= accel_in;
            gyro_ff  <= gyro_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         status_ff  <= status_in;
         samples_ff <= samples_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      acnt_ff <= CAP && gcnt_ff <= CAP)
      else $error("sample count above capacity");
`endif

endmodule

[rtl/imu_fifo_frame_parser_unit.sv]
// Top level of the IMU FIFO frame parser: parser front end, command queue, store back end.
// Depends on ifp_pkg, ifp_parser, ifp_cmd_queue and ifp_store.
//
//   channel   direction   tdata                      tuser
//   req_      in          data_byte[7:0]             operation[1:0], burst_start[2]
//   rsp_      out         x[15:0] y[31:16] z[47:32]  status[2:0]
//
// One request per cycle is accepted while the command queue is not full; each gives exactly one response.
// A request is registered in the command queue and then in the store's response register before its response leaves.
// req_tready drops only when the two-entry command queue is full.
// Reset clears parse state, sample counts, latest triples and the queue.
module imu_fifo_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte[7:0]
   input  logic [2:0]  req_tuser,    // operation[1:0], burst_start[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // sample_x[15:0], sample_y[31:16], sample_z[47:32]
   output logic [2:0]  rsp_tuser     // status[2:0]
);
   import ifp_pkg::*;

   logic    req_fire;
   logic    queue_full;
   logic    queue_valid;
   logic    queue_pop;
   cmd_type front_cmd;
   cmd_type back_cmd;

   assign req_tready = !queue_full;
   assign req_fire   = req_tvalid && req_tready;

   ifp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .operation   (req_tuser[1:0]),
      .data_byte   (req_tdata),
      .burst_start (req_tuser[2]),
      .cmd         (front_cmd)
   );

   ifp_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_cmd   (back_cmd)
   );

   ifp_store u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (queue_valid),
      .cmd         (back_cmd),
      .cmd_pop     (queue_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_samples (rsp_tdata)
   );

endmodule

[sim/imu_fifo_frame_parser_unit_tb.sv]
// Self-checking testbench for imu_fifo_frame_parser_unit: directed frames, random FIFO streams,
// a back-to-back frame pass and random idling on both channels, checked by an internal decoder model.
// Depends on ifp_pkg and the imu_fifo_frame_parser_unit RTL.
module imu_fifo_frame_parser_unit_tb;
   import ifp_pkg::*;

   // Control frame types that skip payload bytes
   localparam logic [3:0] CTRL_SKIP_ONE  = 4'd0;
   localparam logic [3:0] CTRL_SKIP_TWO  = 4'd1;
   localparam logic [3:0] CTRL_SKIP_FOUR = 4'd2;

   localparam int PHASE_ITEMS = 420;
   localparam int FILL_FRAMES = 10;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } decoded_result_type;

   class frame_decode_scoreboard;
      decoded_result_type decoded_q[$];
      logic [1:0]    phase;
      logic [3:0]    left;
      logic [1:0]    enables;
      logic [15:0]   words[3];
      logic [7:0]    low_hold;
      logic [10:0]   accel_count;
      logic [10:0]   gyro_count;
      logic [15:0]   last_accel[3];
      logic [15:0]   last_gyro[3];
      int            failures;

      function new();
         phase = PH_HEADER;
         left = '0;
         enables = '0;
         low_hold = '0;
         accel_count = '0;
         gyro_count = '0;
         failures = 0;
         for (int i = 0; i < 3; i++) begin
            words[i] = '0;
            last_accel[i] = '0;
            last_gyro[i] = '0;
         end
      endfunction

      // Finish a triple: store it unless that kind's count is full, then advance the frame
      function void store_triple();
         decoded_result_type r;
         logic          gyro;
         gyro = (enables & EN_GYRO) != 2'b00;
         r.x = words[0];
         r.y = words[1];
         r.z = words[2];
         if ((gyro ? gyro_count : accel_count) >= CAPACITY) begin
            r.status = ST_DROPPED;
         end else if (gyro) begin
            last_gyro = words;
            gyro_count++;
            r.status = ST_GYRO;
         end else begin
            last_accel = words;
            accel_count++;
            r.status = ST_ACCEL;
         end
         decoded_q.push_back(r);
         enables = enables & (gyro ? EN_ACCEL : 2'b00);
         if (enables != 2'b00) left = WORD_BYTES;
         else phase = PH_HEADER;
      endfunction

      function void note_request(logic [1:0] op, logic [7:0] b, logic burst);
         decoded_result_type r;
         int            idx;
         logic [3:0]    kind;
         logic [3:0]    skip;
         r = '0;
         r.status = ST_CONSUMED;
         if (burst) begin
            phase = PH_HEADER;
            left = '0;
            enables = '0;
         end
         case (op)
            OP_READ_ACCEL: begin
               if (accel_count != 0) begin
                  r.status = ST_READ_OK;
                  r.x = last_accel[0];
                  r.y = last_accel[1];
                  r.z = last_accel[2];
               end else begin
                  r.status = ST_READ_EMPTY;
               end
               accel_count = '0;
            end
            OP_READ_GYRO: begin
               if (gyro_count != 0) begin
                  r.status = ST_READ_OK;
                  r.x = last_gyro[0];
                  r.y = last_gyro[1];
                  r.z = last_gyro[2];
               end else begin
                  r.status = ST_READ_EMPTY;
               end
               gyro_count = '0;
            end
            OP_NONE: begin
            end
            default: begin
               if (phase == PH_SKIP) begin
                  if (left > 0) left--;
                  if (left == 0) phase = PH_HEADER;
               end else if (phase == PH_DATA) begin
                  idx = int'(WORD_BYTES - ((left > WORD_BYTES) ? WORD_BYTES : left));
                  if (idx > 5) idx = 5;
                  if (idx % 2 == 0) low_hold = b;
                  else words[idx / 2] = {b, low_hold};
                  left = 4'(5 - idx);
                  if (left == 0) begin
                     store_triple();
                     return;
                  end
               end else begin
                  phase = PH_HEADER;
                  kind = b[5:2];
                  if ((b & HDR_CONTROL) != 8'h00) begin
                     case (kind)
                        CTRL_SKIP_ONE:  skip = 4'd1;
                        CTRL_SKIP_TWO:  skip = 4'd2;
                        CTRL_SKIP_FOUR: skip = 4'd4;
                        default:        skip = 4'd0;
                     endcase
                     if (skip != 0) begin
                        phase = PH_SKIP;
                        left = skip;
                     end
                  end else if ((b & HDR_DATA) != 8'h00) begin
                     enables = kind[1:0];
                     if (enables != 2'b00) begin
                        phase = PH_DATA;
                        left = WORD_BYTES;
                     end
                  end
               end
            end
         endcase
         decoded_q.push_back(r);
      endfunction

      function void check_response(logic [2:0] status, logic [47:0] data);
         decoded_result_type want;
         if (decoded_q.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("response with nothing outstanding: status %0d data %h", status, data);
            return;
         end
         want = decoded_q.pop_front();
         if (status !== want.status || data[15:0] !== want.x || data[31:16] !== want.y ||
             data[47:32] !== want.z) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: status %0d/%0d x %h/%h y %h/%h z %h/%h (expected/actual)",
                        want.status, status, want.x, data[15:0], want.y, data[31:16],
                        want.z, data[47:32]);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // data_byte[7:0]
   logic [2:0]  req_tuser = '0;      // operation[1:0], burst_start[2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // sample_x[15:0], sample_y[31:16], sample_z[47:32]
   logic [2:0]  rsp_tuser;           // status[2:0]

   frame_decode_scoreboard sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;

   imu_fifo_frame_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
   end

   task automatic send_request(input logic [1:0] op, input logic [7:0] b, input logic burst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= {burst, op};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, b, burst);
      items_sent++;
   endtask

   task automatic send_payload(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0:       b = 8'h00;
            1:       b = 8'hff;
            2:       b = 8'h80;
            3:       b = 8'h7f;
            default: b = 8'($urandom_range(255));
         endcase
         // slip in a read now and then; reads leave the parse state alone
         if ($urandom_range(99) < 4)
            send_request($urandom_range(1) ? OP_READ_ACCEL : OP_READ_GYRO,
                         8'($urandom_range(255)), 1'b0);
         send_request(OP_BYTE, b, 1'b0);
      end
   endtask

   // Hold the request side until every outstanding response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.decoded_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_frame();
      int         pick;
      int         n;
      logic       burst;
      logic [3:0] kind;
      logic [7:0] hdr;
      burst = ($urandom_range(99) < 15);
      pick = $urandom_range(99);
      if (pick < 55) begin
         hdr = 8'(HDR_DATA | ($urandom_range(1, 3) << 2) | ($urandom_range(3) << 4) |
                  $urandom_range(3));
         send_request(OP_BYTE, hdr, burst);
         n = (int'(hdr[3]) + int'(hdr[2])) * WORD_BYTES;
         // truncate a few frames so a later burst start has to recover
         if ($urandom_range(99) < 8) n = $urandom_range(n - 1);
         send_payload(n);
      end else if (pick < 70) begin
         kind = 4'(($urandom_range(3) == 3) ? $urandom_range(15) : $urandom_range(2));
         hdr = 8'(HDR_CONTROL | (kind << 2) | ($urandom_range(1) << 7) | $urandom_range(3));
         send_request(OP_BYTE, hdr, burst);
         case (kind)
            CTRL_SKIP_ONE:  n = 1;
            CTRL_SKIP_TWO:  n = 2;
            CTRL_SKIP_FOUR: n = 4;
            default:        n = 0;
         endcase
         send_payload(n);
      end else if (pick < 85) begin
         send_request($urandom_range(1) ? OP_READ_ACCEL : OP_READ_GYRO,
                      8'($urandom_range(255)), burst);
      end else if (pick < 90) begin
         send_request(OP_NONE, 8'($urandom_range(255)), burst);
      end else begin
         send_request(OP_BYTE, 8'($urandom_range(255)), burst);
      end
   endtask

   task automatic run_directed();
      send_request(OP_READ_ACCEL, 8'h00, 1'b0);
      send_request(OP_READ_GYRO, 8'hff, 1'b0);
      send_request(OP_NONE, 8'h5a, 1'b1);
      // control frames: one- and four-byte skips, an unknown type, both header bits
      send_request(OP_BYTE, HDR_CONTROL | (CTRL_SKIP_ONE << 2), 1'b0);
      send_request(OP_BYTE, 8'h81, 1'b0);
      send_request(OP_BYTE, HDR_CONTROL | (CTRL_SKIP_FOUR << 2), 1'b0);
      send_payload(4);
      send_request(OP_BYTE, 8'h4c, 1'b0);
      send_request(OP_BYTE, HDR_CONTROL | HDR_DATA, 1'b0);
      send_request(OP_BYTE, 8'h88, 1'b0);
      // neither header bit, and a data header without enables
      send_request(OP_BYTE, 8'h3c, 1'b0);
      send_request(OP_BYTE, HDR_DATA | 8'h30, 1'b0);
      // gyro then accel triple with extreme words
      send_request(OP_BYTE, HDR_DATA | {4'b0, EN_GYRO | EN_ACCEL, 2'b00}, 1'b0);
      send_request(OP_BYTE, 8'h00, 1'b0);
      send_request(OP_BYTE, 8'h80, 1'b0);
      send_request(OP_BYTE, 8'hff, 1'b0);
      send_request(OP_BYTE, 8'h7f, 1'b0);
      send_request(OP_BYTE, 8'hff, 1'b0);
      send_request(OP_BYTE, 8'hff, 1'b0);
      send_payload(6);
      // burst start in the middle of a gyro frame
      send_request(OP_BYTE, HDR_DATA | {4'b0, EN_GYRO, 2'b00}, 1'b0);
      send_request(OP_BYTE, 8'h12, 1'b0);
      send_request(OP_BYTE, HDR_DATA | {4'b0, EN_ACCEL, 2'b00}, 1'b1);
      send_request(OP_READ_ACCEL, 8'h00, 1'b0);
      send_request(OP_READ_GYRO, 8'h00, 1'b0);
   endtask

   // Run gyro-and-accel frames back to back, then read each count twice
   task automatic fill_store();
      repeat (FILL_FRAMES) begin
         send_request(OP_BYTE, HDR_DATA | {4'b0, EN_GYRO | EN_ACCEL, 2'b00}, 1'b0);
         send_payload(2 * WORD_BYTES);
      end
      send_request(OP_READ_GYRO, 8'h00, 1'b0);
      send_request(OP_READ_ACCEL, 8'h00, 1'b0);
      send_request(OP_READ_GYRO, 8'h00, 1'b0);
      send_request(OP_READ_ACCEL, 8'h00, 1'b0);
   endtask

   initial begin
      int goal;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 68; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) send_random_frame();
         drain();
      end
      send_idle_pct = 0;
      stall_pct = 0;
      fill_store();
      drain();
      repeat (20) @(posedge clock);
      sb.failures += sb.decoded_q.size();
      if (sb.failures == 0) begin
         $display("imu_fifo_frame_parser_unit test passed");
      end else begin
         $display("imu_fifo_frame_parser_unit test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("imu_fifo_frame_parser_unit test failed");
      $finish;
   end

endmodule
